// File: rtl/skt_pkg.sv
// Package for the scored key table: widths, codes and the structs that
// travel between the table cells and the top level. No dependencies.
package skt_pkg;

   localparam int ENTRIES_DEF = 64;
   localparam int KEY_W       = 64;
   localparam int SCORE_W     = 20;
   localparam int TYPE_W      = 2;
   localparam int ETYPE_W     = 3;
   localparam int CNT_W       = 7;
   localparam int STATUS_W    = 3;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_W       = 80;
   localparam int RSP_W       = 120;

   localparam logic [KEY_W-1:0]   LFSR_TAPS     = 64'hD800_0000_0000_0000;
   localparam logic [SCORE_W-1:0] BOOST_RESET   = 20'd10000;
   localparam logic [SCORE_W-1:0] CEILING_RESET = 20'd1000000;
   localparam logic [SCORE_W-1:0] INIT_RESET    = 20'd1000;
   localparam logic [KEY_W-1:0]   SEED_RESET    = 64'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_BOOST  = 2'd2,
      MODE_EVICT  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_INVALID   = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_DUPLICATE = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOOST   = 3'd0,
      REG_CEILING = 3'd1,
      REG_INIT_S  = 3'd2,
      REG_INIT_L  = 3'd3,
      REG_SEED    = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_FILL  = 2'd1,
      WR_SHORT = 2'd2,
      WR_DROP  = 2'd3
   } wr_kind_type;

   // Search word that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic               active;
      logic [KEY_W-1:0]   key;
      logic               found;
      logic [TYPE_W-1:0]  f_type;
      logic [SCORE_W-1:0] f_short;
      logic [SCORE_W-1:0] f_long;
      logic               free_found;
      logic               min_found;
      logic [SCORE_W-1:0] min_score;
   } probe_type;

   // Update broadcast to all cells; the addressed cell applies it.
   typedef struct packed {
      wr_kind_type        kind;
      logic [KEY_W-1:0]   key;
      logic [TYPE_W-1:0]  etype;
      logic [SCORE_W-1:0] score_s;
      logic [SCORE_W-1:0] score_l;
   } wr_type;

endpackage

// File: rtl/scored_key_table_with_min_eviction_unit.sv
// Top level of the scored key table: request decode, key generator,
// control sequencer and the row of skt_cell slots. Depends on skt_pkg.
//
//  channel  | direction | word
//  req_     | in        | mode, key, entry_type, reserved_nonzero, evict_count
//  rsp_     | out       | status, result_key, result_type, short, long, evicted
//  csr_     | in        | register write, no read-back
//
// Insert, lookup and boost send one search word down the cell row, and the
// response follows once it leaves the row. Evict repeats the walk once per
// removed entry and stops at evict_count or after a walk that finds the
// table empty. An invalid request or an evict of zero entries skips the walk
// and goes straight to the output state.
// Reset empties the table at once; no clearing pass is needed.
// A request is taken only while idle with no response word waiting, so a
// stall on rsp_tready holds req_tready low.
module scored_key_table_with_min_eviction_unit #(
   parameter int ENTRIES = skt_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[1:0], key[65:2], entry_type[68:66], reserved_nonzero[69],
   // evict_count[76:70], zero fill
   input  logic [skt_pkg::REQ_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[2:0], result_key[66:3], result_type[68:67], short_score[88:69],
   // long_score[108:89], evicted[115:109], zero fill
   output logic [skt_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_we,
   input  logic [skt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [skt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import skt_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_type;

   state_type          state_ff;
   logic [SCORE_W-1:0] boost_ff, ceil_ff, init_s_ff, init_l_ff;
   logic [KEY_W-1:0]   lfsr_ff, lfsr_step;

   mode_type           mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [TYPE_W-1:0]  etype_ff;
   logic [CNT_W-1:0]   want_ff, freed_ff;
   logic               launch_ff, launch_in;

   logic [STATUS_W-1:0] r_status_ff;
   logic [KEY_W-1:0]    r_key_ff;
   logic [TYPE_W-1:0]   r_type_ff;
   logic [SCORE_W-1:0]  r_short_ff, r_long_ff;
   logic [CNT_W-1:0]    r_evicted_ff;
   logic                rsp_valid_ff;

   mode_type          in_mode;
   logic [KEY_W-1:0]  in_key;
   logic [ETYPE_W-1:0] in_etype;
   logic              in_res;
   logic [CNT_W-1:0]  in_cnt;
   logic              accept;
   logic              ins_ok, early_invalid, early_out, evict_more;

   probe_type         head;
   probe_type         chain   [0:ENTRIES];
   logic [IW-1:0]     f_idx   [0:ENTRIES];
   logic [IW-1:0]     fr_idx  [0:ENTRIES];
   logic [IW-1:0]     m_idx   [0:ENTRIES];
   probe_type         tail;
   wr_type            wr;
   logic [IW-1:0]     wr_idx;
   logic [SCORE_W:0]  boost_sum;
   logic [SCORE_W-1:0] boost_new;
   logic              done;

   assign in_mode  = mode_type'(req_tdata[1:0]);
   assign in_key   = req_tdata[65:2];
   assign in_etype = req_tdata[68:66];
   assign in_res   = req_tdata[69];
   assign in_cnt   = req_tdata[76:70];

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign lfsr_step  = {1'b0, lfsr_ff[KEY_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   // Request classification at acceptance.
   assign ins_ok        = (in_mode == MODE_INSERT) && !in_res &&
                          (in_etype >= 3'd1) && (in_etype <= 3'd3);
   assign early_invalid = ((in_mode == MODE_INSERT) && !ins_ok) ||
                          (((in_mode == MODE_LOOKUP) || (in_mode == MODE_BOOST)) && in_res);
   assign early_out     = early_invalid || ((in_mode == MODE_EVICT) && (in_cnt == '0));

   // Head of the chain: a fresh search word.
   always_comb begin
      head        = '0;
      head.active = launch_ff;
      head.key    = key_ff;
   end

   assign chain[0]  = head;
   assign f_idx[0]  = '0;
   assign fr_idx[0] = '0;
   assign m_idx[0]  = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      skt_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .probe_in      (chain[g]),
         .found_idx_in  (f_idx[g]),
         .free_idx_in   (fr_idx[g]),
         .min_idx_in    (m_idx[g]),
         .wr            (wr),
         .wr_idx        (wr_idx),
         .probe_out     (chain[g+1]),
         .found_idx_out (f_idx[g+1]),
         .free_idx_out  (fr_idx[g+1]),
         .min_idx_out   (m_idx[g+1])
      );
   end

   assign tail = chain[ENTRIES];
   assign done = (state_ff == S_SCAN) && tail.active;

   // Another eviction walk follows while entries remain and the count allows.
   assign evict_more = done && (mode_ff == MODE_EVICT) && tail.min_found &&
                       ((freed_ff + 1'b1) < want_ff);
   assign launch_in  = (accept && !early_out) || evict_more;

   // Saturating boost of the found entry.
   assign boost_sum = {1'b0, tail.f_short} + {1'b0, boost_ff};
   assign boost_new = (boost_sum > {1'b0, ceil_ff}) ? ceil_ff : boost_sum[SCORE_W-1:0];

   // Slot update issued when the search word leaves the row.
   always_comb begin
      wr         = '0;
      wr.kind    = WR_NONE;
      wr.key     = key_ff;
      wr.etype   = etype_ff;
      wr.score_s = init_s_ff;
      wr.score_l = init_l_ff;
      wr_idx     = fr_idx[ENTRIES];
      if (done) begin
         unique case (mode_ff)
            MODE_INSERT: begin
               if (!tail.found && tail.free_found) wr.kind = WR_FILL;
            end
            MODE_BOOST: begin
               if (tail.found) begin
                  wr.kind    = WR_SHORT;
                  wr.score_s = boost_new;
                  wr_idx     = f_idx[ENTRIES];
               end
            end
            MODE_EVICT: begin
               if (tail.min_found) begin
                  wr.kind = WR_DROP;
                  wr_idx  = m_idx[ENTRIES];
               end
            end
            default: wr.kind = WR_NONE;
         endcase
      end
   end

   // Configuration registers and key generator.
   always_ff @(posedge clock) begin
      if (reset) begin
         boost_ff  <= BOOST_RESET;
         ceil_ff   <= CEILING_RESET;
         init_s_ff <= INIT_RESET;
         init_l_ff <= INIT_RESET;
         lfsr_ff   <= SEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BOOST:   boost_ff  <= csr_wdata[SCORE_W-1:0];
            REG_CEILING: ceil_ff   <= csr_wdata[SCORE_W-1:0];
            REG_INIT_S:  init_s_ff <= csr_wdata[SCORE_W-1:0];
            REG_INIT_L:  init_l_ff <= csr_wdata[SCORE_W-1:0];
            REG_SEED:    lfsr_ff   <= (csr_wdata == '0) ? SEED_RESET : csr_wdata;
            default:     ;
         endcase
      end else if (accept && ins_ok) begin
         lfsr_ff <= lfsr_step;
      end
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= launch_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff      <= in_mode;
                  key_ff       <= ins_ok ? lfsr_step : in_key;
                  etype_ff     <= in_etype[TYPE_W-1:0];
                  want_ff      <= in_cnt;
                  freed_ff     <= '0;
                  r_status_ff  <= early_invalid ? STAT_INVALID : STAT_OK;
                  r_key_ff     <= ins_ok ? lfsr_step : in_key;
                  r_type_ff    <= '0;
                  r_short_ff   <= '0;
                  r_long_ff    <= '0;
                  r_evicted_ff <= '0;
                  state_ff     <= early_out ? S_OUT : S_SCAN;
               end
            end
            S_SCAN: begin
               if (done) begin
                  state_ff <= evict_more ? S_SCAN : S_OUT;
                  unique case (mode_ff)
                     MODE_INSERT: begin
                        if (tail.found) begin
                           r_status_ff <= STAT_DUPLICATE;
                        end else if (!tail.free_found) begin
                           r_status_ff <= STAT_FULL;
                        end else begin
                           r_type_ff  <= etype_ff;
                           r_short_ff <= init_s_ff;
                           r_long_ff  <= init_l_ff;
                        end
                     end
                     MODE_LOOKUP, MODE_BOOST: begin
                        if (!tail.found) begin
                           r_status_ff <= STAT_NOT_FOUND;
                        end else begin
                           r_type_ff  <= tail.f_type;
                           r_short_ff <= (mode_ff == MODE_BOOST) ? boost_new : tail.f_short;
                           r_long_ff  <= tail.f_long;
                        end
                     end
                     MODE_EVICT: begin
                        if (tail.min_found) begin
                           freed_ff     <= freed_ff + 1'b1;
                           r_evicted_ff <= freed_ff + 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, r_evicted_ff, r_long_ff, r_short_ff, r_type_ff,
                        r_key_ff, r_status_ff};

`ifndef ASSERT_OFF
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> state_ff == S_SCAN)
      else $error("search word left the row outside a scan");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");
   a_evict_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mode_ff == MODE_EVICT) |-> freed_ff < want_ff)
      else $error("eviction ran past the requested count");
   a_write_on_done: assert property (@(posedge clock) disable iff (reset)
      (wr.kind != WR_NONE) |-> done)
      else $error("slot update outside scan completion");
`endif

endmodule

// File: rtl/skt_cell.sv
// One table slot with its stage of the search chain.
// Depends on skt_pkg for the probe and update structs.
module skt_cell #(
   parameter int ENTRIES = skt_pkg::ENTRIES_DEF,
   parameter int IDX     = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  skt_pkg::probe_type           probe_in,
   input  logic [$clog2(ENTRIES)-1:0]   found_idx_in,
   input  logic [$clog2(ENTRIES)-1:0]   free_idx_in,
   input  logic [$clog2(ENTRIES)-1:0]   min_idx_in,
   input  skt_pkg::wr_type              wr,
   input  logic [$clog2(ENTRIES)-1:0]   wr_idx,
   output skt_pkg::probe_type           probe_out,
   output logic [$clog2(ENTRIES)-1:0]   found_idx_out,
   output logic [$clog2(ENTRIES)-1:0]   free_idx_out,
   output logic [$clog2(ENTRIES)-1:0]   min_idx_out
);
   import skt_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic               valid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [TYPE_W-1:0]  type_ff;
   logic [SCORE_W-1:0] short_ff;
   logic [SCORE_W-1:0] long_ff;

   probe_type          probe_in_c;
   logic [IW-1:0]      found_idx_in_c, free_idx_in_c, min_idx_in_c;
   probe_type          probe_ff;
   logic [IW-1:0]      found_idx_ff, free_idx_ff, min_idx_ff;
   logic               hit, wr_me;

   assign wr_me = (wr_idx == MY_IDX) && (wr.kind != WR_NONE);

   // Slot contents: only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_me) begin
         unique case (wr.kind)
            WR_FILL:  valid_ff <= 1'b1;
            WR_DROP:  valid_ff <= 1'b0;
            default:  valid_ff <= valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_me && wr.kind == WR_FILL) begin
         key_ff   <= wr.key;
         type_ff  <= wr.etype;
         short_ff <= wr.score_s;
         long_ff  <= wr.score_l;
      end else if (wr_me && wr.kind == WR_SHORT) begin
         short_ff <= wr.score_s;
      end
   end

   // Fold this slot into the passing search word.
   assign hit = valid_ff && !probe_in.found && (probe_in.key != '0) &&
                (key_ff == probe_in.key);

   always_comb begin
      probe_in_c     = probe_in;
      found_idx_in_c = found_idx_in;
      free_idx_in_c  = free_idx_in;
      min_idx_in_c   = min_idx_in;
      if (hit) begin
         probe_in_c.found   = 1'b1;
         probe_in_c.f_type  = type_ff;
         probe_in_c.f_short = short_ff;
         probe_in_c.f_long  = long_ff;
         found_idx_in_c     = MY_IDX;
      end
      if (!valid_ff && !probe_in.free_found) begin
         probe_in_c.free_found = 1'b1;
         free_idx_in_c         = MY_IDX;
      end
      // Strict compare keeps ties on the lower slot.
      if (valid_ff && (!probe_in.min_found || short_ff < probe_in.min_score)) begin
         probe_in_c.min_found = 1'b1;
         probe_in_c.min_score = short_ff;
         min_idx_in_c         = MY_IDX;
      end
   end

   // Search word stage; reset clears it so no stale word is active.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_c;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff <= found_idx_in_c;
      free_idx_ff  <= free_idx_in_c;
      min_idx_ff   <= min_idx_in_c;
   end

   assign probe_out     = probe_ff;
   assign found_idx_out = found_idx_ff;
   assign free_idx_out  = free_idx_ff;
   assign min_idx_out   = min_idx_ff;

endmodule

// File: sim/scored_key_table_with_min_eviction_unit_tb.sv
// Self-checking bench for the scored key table: drives request words, predicts
// each response word with a local table model and compares. Depends on skt_pkg.
`timescale 1ns / 100ps

module scored_key_table_with_min_eviction_unit_tb;
   import skt_pkg::*;

   localparam int NSLOT   = 64;
   localparam int WD_LIMIT = 40000;

   typedef struct packed {
      logic [6:0]         evict_count;
      logic               reserved_nonzero;
      logic [ETYPE_W-1:0] entry_type;
      logic [KEY_W-1:0]   key;
      mode_type           mode;
   } req_word_t;

   typedef struct packed {
      logic [6:0]         evicted;
      logic [SCORE_W-1:0] long_score;
      logic [SCORE_W-1:0] short_score;
      logic [TYPE_W-1:0]  result_type;
      logic [KEY_W-1:0]   result_key;
      status_type         status;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   csr_reg_type csr_index = REG_BOOST;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   scored_key_table_with_min_eviction_unit u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted table contents and registers.
   logic               tbl_valid [NSLOT];
   logic [KEY_W-1:0]   tbl_key   [NSLOT];
   logic [1:0]         tbl_type  [NSLOT];
   logic [SCORE_W-1:0] tbl_short [NSLOT];
   logic [SCORE_W-1:0] tbl_long  [NSLOT];
   logic [KEY_W-1:0]   key_gen;
   int                 live;
   logic [SCORE_W-1:0] boost_amt, ceiling, init_short, init_long;

   req_word_t pending_reqs[$];
   rsp_word_t expected_rsps[$];
   bit        failed = 0;
   int        idle_cycles = 0;
   int        rsp_gap = 0;
   int        req_gap = 0;

   // Sampled handshake state from the last rising edge.
   logic req_tready_s = 1'b0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic int slot_of(logic [KEY_W-1:0] k);
      if (k == 0) return -1;
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   // Apply one request to the local table and return the expected response.
   function automatic rsp_word_t table_step(req_word_t q);
      rsp_word_t r;
      int s, victim;
      logic [SCORE_W:0] sum;
      r = '0;
      r.status = STAT_OK;
      r.result_key = q.key;
      case (q.mode)
         MODE_INSERT: begin
            if (q.reserved_nonzero || q.entry_type < 1 || q.entry_type > 3) begin
               r.status = STAT_INVALID;
               return r;
            end
            key_gen = key_gen[0] ? ((key_gen >> 1) ^ LFSR_TAPS) : (key_gen >> 1);
            r.result_key = key_gen;
            if (slot_of(key_gen) >= 0) begin
               r.status = STAT_DUPLICATE;
               return r;
            end
            s = -1;
            for (int i = 0; i < NSLOT; i++)
               if (!tbl_valid[i] && s < 0) s = i;
            if (s < 0) begin
               r.status = STAT_FULL;
               return r;
            end
            tbl_valid[s] = 1'b1;
            tbl_key[s] = key_gen;
            tbl_type[s] = q.entry_type[1:0];
            tbl_short[s] = init_short;
            tbl_long[s] = init_long;
            live++;
            r.result_type = tbl_type[s];
            r.short_score = tbl_short[s];
            r.long_score = tbl_long[s];
         end
         MODE_LOOKUP, MODE_BOOST: begin
            if (q.reserved_nonzero) begin
               r.status = STAT_INVALID;
               return r;
            end
            s = slot_of(q.key);
            if (s < 0) begin
               r.status = STAT_NOT_FOUND;
               return r;
            end
            if (q.mode == MODE_BOOST) begin
               sum = tbl_short[s] + boost_amt;
               tbl_short[s] = (sum > ceiling) ? ceiling : sum[SCORE_W-1:0];
            end
            r.result_type = tbl_type[s];
            r.short_score = tbl_short[s];
            r.long_score = tbl_long[s];
         end
         default: begin
            // Remove the lowest short score first; ties go to the lowest slot.
            while (r.evicted < q.evict_count && live > 0) begin
               victim = -1;
               for (int i = 0; i < NSLOT; i++)
                  if (tbl_valid[i] && (victim < 0 || tbl_short[i] < tbl_short[victim]))
                     victim = i;
               tbl_valid[victim] = 1'b0;
               live--;
               r.evicted++;
            end
         end
      endcase
      return r;
   endfunction

   // Driver: presents queued words with random gaps and drops rsp_tready at random.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_s) begin
            req_gap = gap_len();
         end
         if (!(req_tvalid && !req_tready_s)) begin
            if (req_gap > 0 || pending_reqs.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end else begin
               req_tdata <= REQ_W'(pending_reqs.pop_front());
               req_tvalid <= 1'b1;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap = gap_len();
         end
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted response.
   always @(posedge clock) begin
      rsp_word_t got, exp;
      bit moved;
      moved = 1'b0;
      req_tready_s <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(table_step(req_word_t'(req_tdata[76:0])));
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got = rsp_word_t'(rsp_tdata[115:0]);
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, got);
               failed = 1;
            end else begin
               exp = expected_rsps.pop_front();
               if (got.status !== exp.status || got.result_key !== exp.result_key ||
                   got.result_type !== exp.result_type ||
                   got.short_score !== exp.short_score ||
                   got.long_score !== exp.long_score || got.evicted !== exp.evicted) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp, got);
                  failed = 1;
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic csr_write(csr_reg_type idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_BOOST:   boost_amt = val[19:0];
         REG_CEILING: ceiling = val[19:0];
         REG_INIT_S:  init_short = val[19:0];
         REG_INIT_L:  init_long = val[19:0];
         default:     key_gen = (val == 0) ? 64'd1 : val;
      endcase
   endtask

   task automatic push_req(mode_type m, logic [63:0] k, logic [2:0] et, logic rsv,
                           logic [6:0] cnt);
      req_word_t q;
      q.mode = m;
      q.key = k;
      q.entry_type = et;
      q.reserved_nonzero = rsv;
      q.evict_count = cnt;
      pending_reqs.push_back(q);
   endtask

   // Waits until every queued request is sent and every expected response is checked, then lets the block settle.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Keys held in the model's slots, valid or not, or now and then a random key, used to aim lookups and boosts.
   function automatic logic [63:0] pick_key();
      int s;
      if ($urandom_range(0, 9) < 2) return {$urandom, $urandom};
      s = $urandom_range(0, NSLOT - 1);
      return tbl_key[s] === 'x ? 64'd0 : tbl_key[s];
   endfunction

   task automatic random_phase(int n);
      int m;
      for (int i = 0; i < n; i++) begin
         m = $urandom_range(0, 99);
         if (m < 35)
            push_req(MODE_INSERT, {$urandom, $urandom},
                     ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 3)),
                     $urandom_range(0, 19) == 0, 7'($urandom));
         else if (m < 90)
            push_req(m < 60 ? MODE_LOOKUP : MODE_BOOST, pick_key(), 3'($urandom),
                     $urandom_range(0, 19) == 0, 7'($urandom));
         else
            push_req(MODE_EVICT, {$urandom, $urandom}, 3'($urandom), 1'($urandom),
                     ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 6)));
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i] = '0;
      end
      key_gen = SEED_RESET;
      live = 0;
      boost_amt = BOOST_RESET;
      ceiling = CEILING_RESET;
      init_short = INIT_RESET;
      init_long = INIT_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every mode, bad types, reserved flag, zero key.
      push_req(MODE_INSERT, 64'd0, 3'd1, 1'b0, 7'd0);
      push_req(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 3'd3, 1'b0, 7'd127);
      push_req(MODE_INSERT, 64'h5, 3'd0, 1'b0, 7'd0);
      push_req(MODE_INSERT, 64'h6, 3'd7, 1'b0, 7'd0);
      push_req(MODE_INSERT, 64'h7, 3'd2, 1'b1, 7'd0);
      push_req(MODE_LOOKUP, 64'h2, 3'd0, 1'b0, 7'd0);
      push_req(MODE_LOOKUP, 64'd0, 3'd0, 1'b0, 7'd0);
      push_req(MODE_LOOKUP, 64'h2, 3'd0, 1'b1, 7'd0);
      push_req(MODE_BOOST, 64'h2, 3'd0, 1'b0, 7'd0);
      push_req(MODE_BOOST, 64'h1234, 3'd0, 1'b0, 7'd0);
      push_req(MODE_BOOST, 64'h2, 3'd0, 1'b1, 7'd0);
      push_req(MODE_EVICT, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1, 7'd0);
      push_req(MODE_EVICT, 64'h0, 3'd0, 1'b0, 7'd1);
      push_req(MODE_EVICT, 64'h0, 3'd0, 1'b0, 7'd127);
      push_req(MODE_EVICT, 64'h0, 3'd0, 1'b0, 7'd64);
      drain();

      // Saturation with a small ceiling; score above a lowered ceiling.
      csr_write(REG_BOOST, 64'd1000000);
      csr_write(REG_INIT_S, 64'd1000000);
      csr_write(REG_INIT_L, 64'hF_FFFF);
      csr_write(REG_SEED, 64'd0);
      csr_write(REG_CEILING, 64'd1000000);
      push_req(MODE_INSERT, 64'd0, 3'd1, 1'b0, 7'd0);
      drain();
      csr_write(REG_CEILING, 64'd0);
      push_req(MODE_BOOST, tbl_key[0], 3'd0, 1'b0, 7'd0);
      drain();
      csr_write(REG_BOOST, 64'd0);

      // Reloading the same seed replays the stored key and gives a duplicate.
      csr_write(REG_SEED, 64'd0);
      push_req(MODE_INSERT, 64'd0, 3'd1, 1'b0, 7'd0);
      drain();

      // Fill the table past full, then random phases with varied settings.
      csr_write(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_CEILING, 64'd500);
      csr_write(REG_INIT_S, 64'd0);
      for (int i = 0; i < 66; i++) push_req(MODE_INSERT, 64'd0, 3'd2, 1'b0, 7'd0);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(REG_BOOST, $urandom_range(0, 1000000));
         csr_write(REG_CEILING, $urandom_range(0, 1000000));
         csr_write(REG_INIT_S, $urandom_range(0, 1000));
         csr_write(REG_INIT_L, $urandom_range(0, 1000000));
         // One phase runs from a small fixed seed instead of a random one.
         csr_write(REG_SEED, (ph == 2) ? 64'd3 : {$urandom, $urandom});
         random_phase(ph == 2 ? 60 : 160);
         drain();
      end

      if (!failed)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
